/* rtl/vlfi_pkg.sv */
// Shared types and constants for the vertex layout find-or-insert block.
`timescale 1ns / 1ps

package vlfi_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Request limits
   localparam int MAX_UV_CHANNELS = 8;
   localparam int MAX_BONES       = 8;

   // Attribute sizes in bytes
   localparam int POS_BYTES    = 12;
   localparam int UV_BYTES     = 8;
   localparam int VEC3_BYTES   = 12;
   localparam int COLOR_BYTES  = 4;
   localparam int WEIGHT_BYTES = 4;

   // Packed layout word: [3:0] uv count, [4] normal, [5] tangent,
   // [6] bitangent, [7] color, [11:8] bone count
   typedef logic [11:0] layout_word_type;

   localparam int BIT_NORMAL    = 4;
   localparam int BIT_TANGENT   = 5;
   localparam int BIT_BITANGENT = 6;
   localparam int BIT_COLOR     = 7;

   typedef enum logic [1:0] {
      STATUS_FOUND = 2'd0,
      STATUS_NEW   = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Byte layout of one vertex format
   typedef struct packed {
      logic [7:0] stride;
      logic [3:0] uv_offset;
      logic [7:0] normal_offset;
      logic [7:0] color_offset;
      logic [7:0] tangent_offset;
      logic [7:0] bitangent_offset;
      logic [7:0] bone_index_offset;
      logic [7:0] bone_weight_offset;
   } layout_type;

   // Start command for the offset sequencer
   typedef struct packed {
      logic            start;
      layout_word_type word;
   } lay_ctrl_type;

endpackage

/* rtl/vlfi_if.sv */
// Request and response channel interfaces for the vertex layout block.
`timescale 1ns / 1ps

interface vlfi_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] uv_channels;
   logic       want_normal;
   logic       want_tangent;
   logic       want_bitangent;
   logic       want_color;
   logic [3:0] bone_influences;

   modport source (output valid, uv_channels, want_normal, want_tangent,
                   want_bitangent, want_color, bone_influences, input ready);
   modport sink   (input valid, uv_channels, want_normal, want_tangent,
                   want_bitangent, want_color, bone_influences, output ready);
endinterface

interface vlfi_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [3:0] entry_index;
   logic [7:0] stride;
   logic [3:0] uv_offset;
   logic [7:0] normal_offset;
   logic [7:0] color_offset;
   logic [7:0] tangent_offset;
   logic [7:0] bitangent_offset;
   logic [7:0] bone_index_offset;
   logic [7:0] bone_weight_offset;

   modport source (output valid, status, entry_index, stride, uv_offset,
                   normal_offset, color_offset, tangent_offset, bitangent_offset,
                   bone_index_offset, bone_weight_offset, input ready);
   modport sink   (input valid, status, entry_index, stride, uv_offset,
                   normal_offset, color_offset, tangent_offset, bitangent_offset,
                   bone_index_offset, bone_weight_offset, output ready);
endinterface

/* rtl/vlfi_layout.sv */
// Offset sequencer: walks the attributes in order with one shared adder.
`timescale 1ns / 1ps

module vlfi_layout (
   input  logic                  clock,
   input  logic                  reset,
   input  vlfi_pkg::lay_ctrl_type ctrl,
   output logic                  done,
   output vlfi_pkg::layout_type  layout
);

   typedef enum logic [6:0] {
      STEP_UV        = 7'b0000001,
      STEP_NORMAL    = 7'b0000010,
      STEP_COLOR     = 7'b0000100,
      STEP_TANGENT   = 7'b0001000,
      STEP_BITANGENT = 7'b0010000,
      STEP_BONE_IDX  = 7'b0100000,
      STEP_BONE_WGT  = 7'b1000000
   } step_type;

   logic                      busy_ff;
   logic                      done_ff;
   step_type                  step_ff;
   step_type                  step_in;
   logic [7:0]                off_ff;
   logic [7:0]                off_in;
   vlfi_pkg::layout_word_type word_ff;
   vlfi_pkg::layout_type      res_ff;
   vlfi_pkg::layout_type      res_in;

   logic [3:0] uvs;
   logic [3:0] bones;
   logic       present;
   logic [7:0] addend;
   logic [7:0] sum;

   assign uvs   = word_ff[3:0];
   assign bones = word_ff[11:8];

   // Per-step presence and size
   always_comb begin
      present = 1'b0;
      addend  = '0;
      case (step_ff)
         STEP_UV: begin
            present = (uvs != '0);
            addend  = {1'b0, uvs, 3'b000};
         end
         STEP_NORMAL: begin
            present = word_ff[vlfi_pkg::BIT_NORMAL];
            addend  = 8'(vlfi_pkg::VEC3_BYTES);
         end
         STEP_COLOR: begin
            present = word_ff[vlfi_pkg::BIT_COLOR];
            addend  = 8'(vlfi_pkg::COLOR_BYTES);
         end
         STEP_TANGENT: begin
            present = word_ff[vlfi_pkg::BIT_TANGENT];
            addend  = 8'(vlfi_pkg::VEC3_BYTES);
         end
         STEP_BITANGENT: begin
            present = word_ff[vlfi_pkg::BIT_BITANGENT];
            addend  = 8'(vlfi_pkg::VEC3_BYTES);
         end
         STEP_BONE_IDX: begin
            present = (bones != '0);
            addend  = {4'b0000, bones};
         end
         STEP_BONE_WGT: begin
            present = (bones != '0);
            addend  = {2'b00, bones, 2'b00};
         end
         default: begin
            present = 1'b0;
            addend  = '0;
         end
      endcase
   end

   // Shared adder
   assign sum = off_ff + addend;

   // Record the running offset into the field of the current step
   always_comb begin
      res_in = res_ff;
      off_in = present ? sum : off_ff;
      if (present) begin
         case (step_ff)
            STEP_UV:        res_in.uv_offset          = off_ff[3:0];
            STEP_NORMAL:    res_in.normal_offset      = off_ff;
            STEP_COLOR:     res_in.color_offset       = off_ff;
            STEP_TANGENT:   res_in.tangent_offset     = off_ff;
            STEP_BITANGENT: res_in.bitangent_offset   = off_ff;
            STEP_BONE_IDX:  res_in.bone_index_offset  = off_ff;
            STEP_BONE_WGT:  res_in.bone_weight_offset = off_ff;
            default:        res_in = res_ff;
         endcase
      end
      if (step_ff == STEP_BONE_WGT) begin
         res_in.stride = off_in;
      end
   end

   // Step order
   always_comb begin
      unique case (step_ff)
         STEP_UV:        step_in = STEP_NORMAL;
         STEP_NORMAL:    step_in = STEP_COLOR;
         STEP_COLOR:     step_in = STEP_TANGENT;
         STEP_TANGENT:   step_in = STEP_BITANGENT;
         STEP_BITANGENT: step_in = STEP_BONE_IDX;
         STEP_BONE_IDX:  step_in = STEP_BONE_WGT;
         STEP_BONE_WGT:  step_in = STEP_BONE_WGT;
         default:        step_in = STEP_UV;
      endcase
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_UV;
      end else begin
         done_ff <= busy_ff && !ctrl.start && (step_ff == STEP_BONE_WGT);
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_UV;
         end else if (busy_ff) begin
            if (step_ff == STEP_BONE_WGT) begin
               busy_ff <= 1'b0;
            end else begin
               step_ff <= step_in;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         word_ff <= ctrl.word;
         off_ff  <= 8'(vlfi_pkg::POS_BYTES);
         res_ff  <= '0;
      end else if (busy_ff) begin
         off_ff <= off_in;
         res_ff <= res_in;
      end
   end

   assign done   = done_ff;
   assign layout = res_ff;

endmodule

/* rtl/vertex_layout_find_or_insert.sv */
// Top level: vertex layout table search and append with response register.
`timescale 1ns / 1ps

// Looks up a vertex layout in a 16-entry table and appends it when absent.
// A request is taken only while the block is idle. The table is searched
// one entry at a time from entry 0 through a single registered read port and
// one comparator, with a read state and a compare state per stored entry;
// the byte offsets are then produced by a seven-step sequencer sharing one
// adder. A miss on a full table skips the sequencer. The result waits in an
// output register until taken; a new request may be accepted meanwhile, and
// its result is held back until the register frees.
// Status reports found, newly created, or table full (all other fields zero).

module vertex_layout_find_or_insert (
   input logic        clock,
   input logic        reset,
   vlfi_req_if.sink   req_chan,
   vlfi_rsp_if.source rsp_chan
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_CMP    = 6'b000100,
      ST_MISS   = 6'b001000,
      ST_LAYOUT = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   typedef struct packed {
      vlfi_pkg::status_type status;
      logic [3:0]           entry_index;
      vlfi_pkg::layout_type layout;
   } rsp_type;

   state_type state_ff;
   state_type state_in;

   logic [vlfi_pkg::CNT_W-1:0] used_ff;
   logic [vlfi_pkg::IDX_W-1:0] idx_ff;
   vlfi_pkg::layout_word_type  req_ff;
   vlfi_pkg::layout_word_type  rd_data_ff;
   vlfi_pkg::status_type       status_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff;

   vlfi_pkg::layout_word_type  layout_table [vlfi_pkg::TABLE_DEPTH];

   vlfi_pkg::lay_ctrl_type     lay_ctrl;
   logic                       lay_done;
   vlfi_pkg::layout_type       lay_result;

   logic                       req_fire;
   logic                       rsp_free;
   logic                       match;
   logic                       last_entry;
   logic                       table_full;
   logic [3:0]                 uv_sat;
   logic [3:0]                 bone_sat;
   vlfi_pkg::layout_word_type  req_word;

   // Request saturation and packing
   assign uv_sat   = (req_chan.uv_channels > 4'(vlfi_pkg::MAX_UV_CHANNELS)) ?
                     4'(vlfi_pkg::MAX_UV_CHANNELS) : req_chan.uv_channels;
   assign bone_sat = (req_chan.bone_influences > 4'(vlfi_pkg::MAX_BONES)) ?
                     4'(vlfi_pkg::MAX_BONES) : req_chan.bone_influences;
   assign req_word = {bone_sat, req_chan.want_color, req_chan.want_bitangent,
                      req_chan.want_tangent, req_chan.want_normal, uv_sat};

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // Shared comparator: equal counts, requested flags all present
   assign match = (rd_data_ff[11:8] == req_ff[11:8]) &&
                  (rd_data_ff[3:0] == req_ff[3:0]) &&
                  ((rd_data_ff[7:4] & req_ff[7:4]) == req_ff[7:4]);
   assign last_entry = ((vlfi_pkg::CNT_W'(idx_ff) + 1'b1) == used_ff);
   assign table_full = (used_ff == vlfi_pkg::CNT_W'(vlfi_pkg::TABLE_DEPTH));

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = (used_ff == '0) ? ST_MISS : ST_READ;
         ST_READ:   state_in = ST_CMP;
         ST_CMP: begin
            if (match) begin
               state_in = ST_LAYOUT;
            end else if (last_entry) begin
               state_in = ST_MISS;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_MISS:   state_in = table_full ? ST_EMIT : ST_LAYOUT;
         ST_LAYOUT: if (lay_done) state_in = ST_EMIT;
         ST_EMIT:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Kick the offset sequencer on a hit or an append
   always_comb begin
      lay_ctrl.start = 1'b0;
      lay_ctrl.word  = req_ff;
      if (state_ff == ST_CMP && match) begin
         lay_ctrl.start = 1'b1;
         lay_ctrl.word  = rd_data_ff;
      end else if (state_ff == ST_MISS && !table_full) begin
         lay_ctrl.start = 1'b1;
      end
   end

   vlfi_layout u_layout (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lay_ctrl),
      .done   (lay_done),
      .layout (lay_result)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_MISS && !table_full) begin
            used_ff <= used_ff + 1'b1;
         end
         if (state_ff == ST_EMIT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Search datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_word;
         idx_ff <= '0;
      end else if (state_ff == ST_CMP && !match && !last_entry) begin
         idx_ff <= idx_ff + 1'b1;
      end else if (state_ff == ST_MISS) begin
         idx_ff <= used_ff[vlfi_pkg::IDX_W-1:0];
      end
      if (state_ff == ST_CMP && match) begin
         status_ff <= vlfi_pkg::STATUS_FOUND;
      end else if (state_ff == ST_MISS) begin
         status_ff <= table_full ? vlfi_pkg::STATUS_FULL : vlfi_pkg::STATUS_NEW;
      end
   end

   // Layout table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == ST_MISS && !table_full) begin
         layout_table[used_ff[vlfi_pkg::IDX_W-1:0]] <= req_ff;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= layout_table[idx_ff];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && rsp_free) begin
         rsp_ff.status <= status_ff;
         if (status_ff == vlfi_pkg::STATUS_FULL) begin
            rsp_ff.entry_index <= '0;
            rsp_ff.layout      <= '0;
         end else begin
            rsp_ff.entry_index <= 4'(idx_ff);
            rsp_ff.layout      <= lay_result;
         end
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.status             = rsp_ff.status;
   assign rsp_chan.entry_index        = rsp_ff.entry_index;
   assign rsp_chan.stride             = rsp_ff.layout.stride;
   assign rsp_chan.uv_offset          = rsp_ff.layout.uv_offset;
   assign rsp_chan.normal_offset      = rsp_ff.layout.normal_offset;
   assign rsp_chan.color_offset       = rsp_ff.layout.color_offset;
   assign rsp_chan.tangent_offset     = rsp_ff.layout.tangent_offset;
   assign rsp_chan.bitangent_offset   = rsp_ff.layout.bitangent_offset;
   assign rsp_chan.bone_index_offset  = rsp_ff.layout.bone_index_offset;
   assign rsp_chan.bone_weight_offset = rsp_ff.layout.bone_weight_offset;

   // Checks
   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= vlfi_pkg::CNT_W'(vlfi_pkg::TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (vlfi_pkg::CNT_W'(idx_ff) < used_ff))
      else $error("search reads an unwritten entry");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MISS && !table_full) |=> (used_ff == $past(used_ff) + 1'b1))
      else $error("append did not advance the entry count");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == vlfi_pkg::STATUS_FULL) |->
      (rsp_ff.layout == '0 && rsp_ff.entry_index == '0))
      else $error("table-full response carries nonzero fields");

endmodule
